// ----- hw/rtl/annexb_nal_and_access_unit_splitter_top_macros.svh -----
// assertion macros for the annex b splitter top level
`ifndef ANNEXB_NAL_AND_ACCESS_UNIT_SPLITTER_TOP_MACROS_SVH
`define ANNEXB_NAL_AND_ACCESS_UNIT_SPLITTER_TOP_MACROS_SVH

// same-cycle implication under clock and reset
`define ANNEXB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under clock and reset
`define ANNEXB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/annexb_pkg.sv -----
// shared types and constants of the annex b splitter
package annexb_pkg;

   localparam int OFFSET_WIDTH = 32;
   localparam int MAX_RESULTS  = 3;
   localparam int RSP_DEPTH    = 4;
   localparam int PUSH_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] KIND_NAL     = 2'd0;
   localparam logic [1:0] KIND_UNIT    = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [4:0] NAL_SLICE_LO = 5'd1;
   localparam logic [4:0] NAL_IDR      = 5'd5;
   localparam logic [4:0] NAL_SPS      = 5'd7;
   localparam logic [4:0] NAL_PPS      = 5'd8;
   localparam logic [4:0] NAL_AUD      = 5'd9;

   localparam logic [2:0] SC_SHORT = 3'd3;
   localparam logic [2:0] SC_LONG  = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] offset;
      logic [31:0] length;
      logic [4:0]  nal_type;
      logic [2:0]  start_code_bytes;
      logic [31:0] sps_start;
      logic [15:0] sps_bytes;
      logic [31:0] pps_start;
      logic [15:0] pps_bytes;
      logic        params_found;
      logic        offset_overflow;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [PUSH_CNT_W-1:0]         count;
      rsp_type [MAX_RESULTS-1:0]     rec;
   } push_type;

endpackage

// ----- hw/rtl/annexb_parse.sv -----
// byte parser: start code window, nal and access unit tracking, record build
module annexb_parse #(
   parameter int OFFSET_WIDTH = annexb_pkg::OFFSET_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                end_of_stream,
   output annexb_pkg::push_type push
);

   localparam int W  = OFFSET_WIDTH;
   localparam int XW = (W + 1 > 32) ? W + 1 : 32;
   localparam logic [W-1:0] POS_MAX = '1;

   function automatic logic [31:0] fit32(input logic [W:0] v);
      logic [XW-1:0] wide;
      wide = XW'(v);
      return wide[31:0];
   endfunction

   logic [W-1:0]  pos_ff, pos_in;
   logic [7:0]    r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic          in_nal_ff, in_nal_in;
   logic          hdr_ff, hdr_in;
   logic [W-1:0]  nal_start_ff, nal_start_in;
   logic [2:0]    code_len_ff, code_len_in;
   logic [4:0]    kind_seen_ff, kind_seen_in;
   logic [W-1:0]  unit_start_ff, unit_start_in;
   logic          unit_open_ff, unit_open_in;
   logic          prev_slice_ff, prev_slice_in;
   logic [31:0]   sps_off_ff, sps_off_in, pps_off_ff, pps_off_in;
   logic [15:0]   sps_bytes_ff, sps_bytes_in, pps_bytes_ff, pps_bytes_in;
   logic          ovf_ff, ovf_in;

   logic [4:0]    hdr_type;
   logic          hb, vcl, fresh, au_en, zero2, mid_close, open_en, long_code;
   logic          pos_at_max, ovf_next, in_nal_mid, hdr_mid, eos_close, close_en;
   logic          close_flag, sps_take, pps_take, unit_open_mid, prev_slice_mid;
   logic [W-1:0]  pos_next, close_end, nal_len, nal_body, code_ext;
   logic [W-1:0]  unit_start_mid, au_len, tail_len, open_start;
   logic [W:0]    hdr_place;
   logic [4:0]    close_kind;
   logic [31:0]   sps_off_mid, pps_off_mid;
   logic [15:0]   sps_bytes_mid, pps_bytes_mid;
   logic [2:0]    cand_en;
   annexb_pkg::rsp_type cand [annexb_pkg::MAX_RESULTS];
   annexb_pkg::push_type push_c;
   logic [annexb_pkg::PUSH_CNT_W-1:0] n;

   always_comb begin
      hdr_type  = data_byte[4:0];
      hb        = in_nal_ff && !hdr_ff;
      vcl       = hdr_type inside {[annexb_pkg::NAL_SLICE_LO : annexb_pkg::NAL_IDR]};
      fresh     = !unit_open_ff || hdr_type == annexb_pkg::NAL_AUD ||
                  (prev_slice_ff && (vcl || hdr_type == annexb_pkg::NAL_SPS));
      au_en     = hb && fresh && unit_open_ff;

      // 00 00 00 or 00 00 01 past the header ends the nal
      zero2     = r2_ff == 8'd0 && r3_ff == 8'd0;
      mid_close = !hb && in_nal_ff && zero2 && data_byte[7:1] == 7'd0;
      open_en   = !hb && !(in_nal_ff && !mid_close) && data_byte == 8'd1 && zero2;
      // a close in the same beat wipes the oldest byte, so the new code is short
      long_code = !mid_close && r1_ff == 8'd0;
      open_start = long_code ? pos_ff - W'(3) : pos_ff - W'(2);

      pos_at_max = pos_ff == POS_MAX;
      pos_next   = pos_at_max ? pos_ff : pos_ff + W'(1);
      ovf_next   = ovf_ff | pos_at_max;

      in_nal_mid = hb | (in_nal_ff & !mid_close) | open_en;
      hdr_mid    = hb | (hdr_ff & !mid_close & !open_en);
      eos_close  = end_of_stream && in_nal_mid && hdr_mid;
      close_en   = mid_close || eos_close;
      close_end  = mid_close ? pos_ff - W'(2) : pos_next;
      close_kind = hb ? hdr_type : kind_seen_ff;
      close_flag = mid_close ? ovf_ff : ovf_next;

      code_ext  = W'(code_len_ff);
      nal_len   = (close_end >= nal_start_ff) ? close_end - nal_start_ff : '0;
      nal_body  = (nal_len >= code_ext) ? nal_len - code_ext : '0;
      hdr_place = {1'b0, nal_start_ff} + (W + 1)'(code_len_ff);

      sps_take = close_en && close_kind == annexb_pkg::NAL_SPS && sps_bytes_ff == 16'd0;
      pps_take = close_en && close_kind == annexb_pkg::NAL_PPS && pps_bytes_ff == 16'd0;
      sps_off_mid   = sps_take ? fit32(hdr_place) : sps_off_ff;
      sps_bytes_mid = sps_take ? nal_body[15:0] : sps_bytes_ff;
      pps_off_mid   = pps_take ? fit32(hdr_place) : pps_off_ff;
      pps_bytes_mid = pps_take ? nal_body[15:0] : pps_bytes_ff;

      unit_start_mid = (hb && fresh) ? nal_start_ff : unit_start_ff;
      unit_open_mid  = unit_open_ff | (hb & fresh);
      prev_slice_mid = hb ? (vcl | (prev_slice_ff & !fresh)) : prev_slice_ff;
      au_len   = (nal_start_ff >= unit_start_ff) ? nal_start_ff - unit_start_ff : '0;
      tail_len = (pos_next >= unit_start_mid) ? pos_next - unit_start_mid : '0;

      cand[0] = '0;
      cand[0].kind            = annexb_pkg::KIND_UNIT;
      cand[0].offset          = fit32({1'b0, unit_start_ff});
      cand[0].length          = fit32({1'b0, au_len});
      cand[0].offset_overflow = ovf_ff;
      cand[0].last            = !close_en && !end_of_stream;

      cand[1] = '0;
      cand[1].kind             = annexb_pkg::KIND_NAL;
      cand[1].offset           = fit32({1'b0, nal_start_ff});
      cand[1].length           = fit32({1'b0, nal_len});
      cand[1].nal_type         = close_kind;
      cand[1].start_code_bytes = code_len_ff;
      cand[1].offset_overflow  = close_flag;
      cand[1].last             = !end_of_stream;

      cand[2] = '0;
      cand[2].kind            = annexb_pkg::KIND_SUMMARY;
      cand[2].offset          = unit_open_mid ? fit32({1'b0, unit_start_mid}) : 32'd0;
      cand[2].length          = unit_open_mid ? fit32({1'b0, tail_len}) : 32'd0;
      cand[2].sps_start       = sps_off_mid;
      cand[2].sps_bytes       = sps_bytes_mid;
      cand[2].pps_start       = pps_off_mid;
      cand[2].pps_bytes       = pps_bytes_mid;
      cand[2].params_found    = sps_bytes_mid != 16'd0 && pps_bytes_mid != 16'd0;
      cand[2].offset_overflow = ovf_next;
      cand[2].last            = 1'b1;

      // pack the records of this beat in stream order
      cand_en = {end_of_stream, close_en, au_en} & {3{take}};
      push_c  = '0;
      n       = '0;
      for (int i = 0; i < annexb_pkg::MAX_RESULTS; i++) begin
         if (cand_en[i]) begin
            push_c.rec[n] = cand[i];
            n = n + 1'b1;
         end
      end
      push_c.count = n;
   end

   assign push = push_c;

   always_comb begin
      pos_in        = pos_ff;
      r1_in         = r1_ff;
      r2_in         = r2_ff;
      r3_in         = r3_ff;
      in_nal_in     = in_nal_ff;
      hdr_in        = hdr_ff;
      nal_start_in  = nal_start_ff;
      code_len_in   = code_len_ff;
      kind_seen_in  = kind_seen_ff;
      unit_start_in = unit_start_ff;
      unit_open_in  = unit_open_ff;
      prev_slice_in = prev_slice_ff;
      sps_off_in    = sps_off_ff;
      sps_bytes_in  = sps_bytes_ff;
      pps_off_in    = pps_off_ff;
      pps_bytes_in  = pps_bytes_ff;
      ovf_in        = ovf_ff;
      if (take) begin
         if (end_of_stream) begin
            // the stream is done: back to the idle state
            pos_in        = '0;
            r1_in         = 8'hff;
            r2_in         = 8'hff;
            r3_in         = 8'hff;
            in_nal_in     = 1'b0;
            hdr_in        = 1'b0;
            nal_start_in  = '0;
            code_len_in   = 3'd0;
            kind_seen_in  = 5'd0;
            unit_start_in = '0;
            unit_open_in  = 1'b0;
            prev_slice_in = 1'b0;
            sps_off_in    = 32'd0;
            sps_bytes_in  = 16'd0;
            pps_off_in    = 32'd0;
            pps_bytes_in  = 16'd0;
            ovf_in        = 1'b0;
         end else begin
            pos_in        = pos_next;
            r1_in         = hb ? 8'hff : r2_ff;
            r2_in         = hb ? 8'hff : r3_ff;
            r3_in         = hb ? 8'hff : data_byte;
            in_nal_in     = in_nal_mid;
            hdr_in        = hdr_mid;
            kind_seen_in  = hb ? hdr_type : kind_seen_ff;
            if (open_en) begin
               nal_start_in = open_start;
               code_len_in  = long_code ? annexb_pkg::SC_LONG : annexb_pkg::SC_SHORT;
            end
            unit_start_in = unit_start_mid;
            unit_open_in  = unit_open_mid;
            prev_slice_in = prev_slice_mid;
            sps_off_in    = sps_off_mid;
            sps_bytes_in  = sps_bytes_mid;
            pps_off_in    = pps_off_mid;
            pps_bytes_in  = pps_bytes_mid;
            ovf_in        = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         r1_ff         <= 8'hff;
         r2_ff         <= 8'hff;
         r3_ff         <= 8'hff;
         in_nal_ff     <= 1'b0;
         hdr_ff        <= 1'b0;
         nal_start_ff  <= '0;
         code_len_ff   <= 3'd0;
         kind_seen_ff  <= 5'd0;
         unit_start_ff <= '0;
         unit_open_ff  <= 1'b0;
         prev_slice_ff <= 1'b0;
         sps_off_ff    <= 32'd0;
         sps_bytes_ff  <= 16'd0;
         pps_off_ff    <= 32'd0;
         pps_bytes_ff  <= 16'd0;
         ovf_ff        <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         r1_ff         <= r1_in;
         r2_ff         <= r2_in;
         r3_ff         <= r3_in;
         in_nal_ff     <= in_nal_in;
         hdr_ff        <= hdr_in;
         nal_start_ff  <= nal_start_in;
         code_len_ff   <= code_len_in;
         kind_seen_ff  <= kind_seen_in;
         unit_start_ff <= unit_start_in;
         unit_open_ff  <= unit_open_in;
         prev_slice_ff <= prev_slice_in;
         sps_off_ff    <= sps_off_in;
         sps_bytes_ff  <= sps_bytes_in;
         pps_off_ff    <= pps_off_in;
         pps_bytes_ff  <= pps_bytes_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

// ----- hw/rtl/annexb_rsp_fifo.sv -----
// result queue: takes up to three records a cycle, hands out one per beat
module annexb_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  annexb_pkg::push_type push,
   input  logic                 pop,
   output annexb_pkg::rsp_type  head,
   output logic                 head_valid,
   output logic                 room
);

   localparam int DEPTH = annexb_pkg::RSP_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   annexb_pkg::rsp_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_idx [annexb_pkg::MAX_RESULTS];

   always_comb begin
      for (int i = 0; i < annexb_pkg::MAX_RESULTS; i++) begin
         wr_idx[i] = wr_ptr_ff + PTR_W'(i);
      end
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   // room for a full beat's worth of records
   assign room       = count_ff <= CNT_W'(DEPTH - annexb_pkg::MAX_RESULTS);

   always_ff @(posedge clock) begin
      for (int i = 0; i < annexb_pkg::MAX_RESULTS; i++) begin
         if (i < int'(push.count)) begin
            entry_ff[wr_idx[i]] <= push.rec[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/annexb_nal_and_access_unit_splitter_top.sv -----
// top level of the annex b nal and access unit splitter
// usage:
//   req_* carries one stream byte per beat; req_end_of_stream marks the last
//   byte and flushes the open nal and access unit, then a summary record
//   with the first sps and pps places follows.
//   rsp_* carries one record per beat: nal records, access unit records and
//   the end-of-stream summary; rsp_last marks the final record of a byte.
// output: records of a byte appear on rsp_* in the cycle after the byte is
//   taken when the result queue is empty.
// throughput: one byte per cycle; a byte yields zero to three records and
//   each record takes one rsp beat, so the four-entry result queue sets the
//   rate: req_stall rises while more than one record waits.
// stall: rsp_stall holds the head record steady; the queue absorbs the
//   records already made and req_stall backs up the byte stream.
// reset: synchronous; clears the parser state and empties the queue. after a
//   flush the parser is back in its reset state and a new stream may start.
`include "annexb_nal_and_access_unit_splitter_top_macros.svh"

module annexb_nal_and_access_unit_splitter_top #(
   parameter int OFFSET_WIDTH = annexb_pkg::OFFSET_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_offset,
   output logic [31:0] rsp_length,
   output logic [4:0]  rsp_nal_type,
   output logic [2:0]  rsp_start_code_bytes,
   output logic [31:0] rsp_sps_start,
   output logic [15:0] rsp_sps_bytes,
   output logic [31:0] rsp_pps_start,
   output logic [15:0] rsp_pps_bytes,
   output logic        rsp_params_found,
   output logic        rsp_offset_overflow,
   output logic        rsp_last
);

   logic                 take;
   logic                 room;
   logic                 pop;
   annexb_pkg::push_type push;
   annexb_pkg::rsp_type  head;

   assign req_stall = !room;
   assign take      = req_valid && room;
   assign pop       = rsp_valid && !rsp_stall;

   annexb_parse #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .data_byte    (req_data_byte),
      .end_of_stream(req_end_of_stream),
      .push         (push)
   );

   annexb_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .head_valid(rsp_valid),
      .room      (room)
   );

   assign rsp_kind             = head.kind;
   assign rsp_offset           = head.offset;
   assign rsp_length           = head.length;
   assign rsp_nal_type         = head.nal_type;
   assign rsp_start_code_bytes = head.start_code_bytes;
   assign rsp_sps_start        = head.sps_start;
   assign rsp_sps_bytes        = head.sps_bytes;
   assign rsp_pps_start        = head.pps_start;
   assign rsp_pps_bytes        = head.pps_bytes;
   assign rsp_params_found     = head.params_found;
   assign rsp_offset_overflow  = head.offset_overflow;
   assign rsp_last             = head.last;

   `ANNEXB_ASSERT_NEXT(a_eos_gives_record, clock, reset,
      req_valid && !req_stall && req_end_of_stream, rsp_valid,
      "end of stream beat produced no record")
   `ANNEXB_ASSERT_NOW(a_summary_is_last, clock, reset,
      rsp_valid && rsp_kind == annexb_pkg::KIND_SUMMARY, rsp_last,
      "summary record not marked last")
   `ANNEXB_ASSERT_NOW(a_nal_code_len, clock, reset,
      rsp_valid && rsp_kind == annexb_pkg::KIND_NAL,
      rsp_start_code_bytes == annexb_pkg::SC_SHORT ||
      rsp_start_code_bytes == annexb_pkg::SC_LONG,
      "nal record with bad start code length")
   `ANNEXB_ASSERT_NOW(a_params_only_in_summary, clock, reset,
      rsp_valid && rsp_params_found, rsp_kind == annexb_pkg::KIND_SUMMARY,
      "params flag outside the summary record")

endmodule
